// ===== hw/rtl/fsp_pkg.sv =====
// shared widths, phase codes, character codes and a helper for the format spec parser
package fsp_pkg;

  localparam int CHAR_W = 8;
  localparam int VAL_W  = 32;
  localparam int PH_W   = 4;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [PH_W-1:0]   phase_t;

  // parser phases
  localparam phase_t PH_BASE  = PH_W'(0);
  localparam phase_t PH_DOT   = PH_W'(1);
  localparam phase_t PH_ZERO  = PH_W'(2);
  localparam phase_t PH_MINUS = PH_W'(3);
  localparam phase_t PH_WDIG  = PH_W'(4);
  localparam phase_t PH_PDIG  = PH_W'(5);
  localparam phase_t PH_ZDIG  = PH_W'(6);
  localparam phase_t PH_NDIG  = PH_W'(7);
  localparam phase_t PH_SKIP  = PH_W'(8);

  // field syntax characters
  localparam char_t CH_STAR  = 8'h2A;
  localparam char_t CH_DOT   = 8'h2E;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_ONE   = 8'h31;
  localparam char_t CH_NINE  = 8'h39;

  localparam val_t VAL_ZERO      = '0;
  localparam val_t VAL_MINUS_ONE = '1;

  typedef struct packed {
    val_t  field_width;
    val_t  zero_pad_width;
    val_t  precision;
    char_t conversion;
  } result_t;

  // acc * 10 as two shifts and an add, wraps at the value width
  function automatic val_t times_ten(input val_t acc);
    return (acc << 3) + (acc << 1);
  endfunction

endpackage

// ===== hw/rtl/fsp_if.sv =====
// valid/ready channel interfaces for spec characters and parsed results
interface fsp_char_if import fsp_pkg::*; (input logic clk);
  logic                    valid;
  logic                    ready;
  logic [CHAR_W-1:0]       ch;
  logic signed [VAL_W-1:0] star_arg;

  modport source (output valid, output ch, output star_arg, input ready);
  modport sink   (input valid, input ch, input star_arg, output ready);
endinterface

interface fsp_result_if import fsp_pkg::*; (input logic clk);
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] field_width;
  logic signed [VAL_W-1:0] zero_pad_width;
  logic signed [VAL_W-1:0] precision;
  logic [CHAR_W-1:0]       conversion;

  modport source (output valid, output field_width, output zero_pad_width,
                  output precision, output conversion, input ready);
  modport sink   (input valid, input field_width, input zero_pad_width,
                  input precision, input conversion, output ready);
endinterface

// ===== hw/rtl/format_spec_field_parser_unit.sv =====
// format specifier field parser: top level with parse state and output skid buffer
//
// usage
//   spec   : sink channel, one character after the percent sign per transfer, with the
//            integer that a star would consume in star_arg
//   result : source channel, one transfer per finished specifier carrying the signed
//            width, the zero-pad width, the precision (-1 if none) and the ending char
//   a NUL or any character outside '*', '.', '-', '0'..'9' ends the specifier
//   throughput: one character per cycle, every cycle, as long as the result side keeps up
//   latency: a result is valid the cycle after its ending transfer if the output is free
//   the parse step is one 4-bit phase decode plus a times-ten add on one accumulator,
//   all between the input transfer and the result register
//   receiver stall: a result waits in the output register; one more finished result is
//   held in a skid register, and characters are taken until that register fills;
//   spec.ready drops only when the skid register is full
//   reset (rst, synchronous, active high): phase to base, width and zero-pad to 0,
//   precision to -1, no pending dot, both result registers empty
module format_spec_field_parser_unit import fsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  fsp_char_if.sink   spec,
  fsp_result_if.source result
);

  // parse state
  phase_t phase, phase_next;
  val_t   width_acc, width_acc_next;
  val_t   zero_acc, zero_acc_next;
  val_t   prec_acc, prec_acc_next;
  logic   last_was_dot, last_was_dot_next;

  // output register and skid stage
  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;

  logic    spec_fire;
  logic    out_fire;
  logic    emit;
  logic    emit_fire;
  logic    load_out;
  logic    is_digit;
  logic    to_base;
  val_t    digit;
  val_t    arg;
  result_t new_result;

  assign spec.ready = !skid_valid;
  assign spec_fire  = spec.valid && spec.ready;
  assign out_fire   = out_valid && result.ready;
  assign emit_fire  = spec_fire && emit;
  assign load_out   = !out_valid || out_fire;

  assign is_digit = (spec.ch >= CH_ZERO) && (spec.ch <= CH_NINE);
  // low nibble of '0'..'9' is the digit value
  assign digit    = {{(VAL_W-4){1'b0}}, spec.ch[3:0]};
  assign arg      = val_t'(spec.star_arg);

  // one parse step
  always_comb begin
    phase_next        = phase;
    width_acc_next    = width_acc;
    zero_acc_next     = zero_acc;
    prec_acc_next     = prec_acc;
    last_was_dot_next = last_was_dot;
    to_base           = 1'b0;
    emit              = 1'b0;

    case (phase)
      PH_DOT: begin
        if (spec.ch == CH_STAR) begin
          prec_acc_next = arg;
          phase_next    = PH_SKIP;
        end else if (is_digit) begin
          prec_acc_next = digit;
          phase_next    = PH_PDIG;
        end else begin
          // dot alone means precision zero
          prec_acc_next = VAL_ZERO;
          to_base       = 1'b1;
        end
      end
      PH_ZERO: begin
        if (spec.ch == CH_DOT) begin
          // zero then dot clears width and precision, a star may follow
          width_acc_next    = VAL_ZERO;
          prec_acc_next     = VAL_ZERO;
          phase_next        = PH_BASE;
          last_was_dot_next = 1'b1;
        end else if (spec.ch == CH_STAR) begin
          zero_acc_next = arg;
          phase_next    = PH_SKIP;
        end else if (is_digit) begin
          zero_acc_next = digit;
          phase_next    = PH_ZDIG;
        end else begin
          zero_acc_next = VAL_ZERO;
          to_base       = 1'b1;
        end
      end
      PH_MINUS: begin
        if (spec.ch == CH_STAR) begin
          // positive argument is negated, others pass as they are
          if (arg != VAL_ZERO && !arg[VAL_W-1]) begin
            width_acc_next = VAL_ZERO - arg;
          end else begin
            width_acc_next = arg;
          end
          phase_next = PH_SKIP;
        end else if (is_digit) begin
          width_acc_next = VAL_ZERO - digit;
          phase_next     = PH_NDIG;
        end else begin
          width_acc_next = VAL_ZERO;
          to_base        = 1'b1;
        end
      end
      PH_WDIG: begin
        if (is_digit) begin
          width_acc_next = times_ten(width_acc) + digit;
        end else begin
          to_base = 1'b1;
        end
      end
      PH_PDIG: begin
        if (is_digit) begin
          prec_acc_next = times_ten(prec_acc) + digit;
        end else begin
          to_base = 1'b1;
        end
      end
      PH_ZDIG: begin
        if (is_digit) begin
          zero_acc_next = times_ten(zero_acc) + digit;
        end else begin
          to_base = 1'b1;
        end
      end
      PH_NDIG: begin
        if (is_digit) begin
          width_acc_next = times_ten(width_acc) - digit;
        end else begin
          to_base = 1'b1;
        end
      end
      PH_SKIP: begin
        // digits after a star that follows a dot, zero or minus are dropped
        if (!is_digit) begin
          to_base = 1'b1;
        end
      end
      default: begin
        to_base = 1'b1;
      end
    endcase

    // base handling, reached from base phase or when a phase sees an unrelated char
    if (to_base) begin
      last_was_dot_next = 1'b0;
      phase_next        = PH_BASE;
      if (spec.ch == CH_STAR) begin
        if (last_was_dot) begin
          prec_acc_next = arg;
        end else begin
          width_acc_next = arg;
        end
      end else if (spec.ch == CH_DOT) begin
        phase_next = PH_DOT;
      end else if (spec.ch == CH_ZERO) begin
        phase_next = PH_ZERO;
      end else if (spec.ch == CH_MINUS) begin
        phase_next = PH_MINUS;
      end else if (spec.ch >= CH_ONE && spec.ch <= CH_NINE) begin
        width_acc_next = digit;
        phase_next     = PH_WDIG;
      end else begin
        emit = 1'b1;
      end
    end

    new_result.field_width    = width_acc_next;
    new_result.zero_pad_width = zero_acc_next;
    new_result.precision      = prec_acc_next;
    new_result.conversion     = spec.ch;

    // ending character clears everything for the next specifier
    if (emit) begin
      phase_next        = PH_BASE;
      width_acc_next    = VAL_ZERO;
      zero_acc_next     = VAL_ZERO;
      prec_acc_next     = VAL_MINUS_ONE;
      last_was_dot_next = 1'b0;
    end
  end

  // parse state registers, advance on each spec transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_BASE;
      width_acc    <= VAL_ZERO;
      zero_acc     <= VAL_ZERO;
      prec_acc     <= VAL_MINUS_ONE;
      last_was_dot <= 1'b0;
    end else if (spec_fire) begin
      phase        <= phase_next;
      width_acc    <= width_acc_next;
      zero_acc     <= zero_acc_next;
      prec_acc     <= prec_acc_next;
      last_was_dot <= last_was_dot_next;
    end
  end

  // output register with skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= emit_fire;
      end else begin
        out_valid  <= emit_fire;
      end
    end else if (emit_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        skid_data <= new_result;
      end else begin
        out_data  <= new_result;
      end
    end else if (emit_fire) begin
      skid_data <= new_result;
    end
  end

  assign result.valid          = out_valid;
  assign result.field_width    = out_data.field_width;
  assign result.zero_pad_width = out_data.zero_pad_width;
  assign result.precision      = out_data.precision;
  assign result.conversion     = out_data.conversion;

  // skid stage only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while output register is empty");

  // ending transfer with nothing waiting shows up in the output register next cycle
  a_emit_to_out: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && !out_valid) |=> (out_valid && out_data.conversion == $past(spec.ch)))
    else $error("finished specifier did not reach the output register");

  // ending transfer leaves the parser in its cleared state
  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    emit_fire |=> (phase == PH_BASE && width_acc == VAL_ZERO && zero_acc == VAL_ZERO
                   && prec_acc == VAL_MINUS_ONE && !last_was_dot))
    else $error("parse state not cleared after a finished specifier");

  // pending zero-dot only ever sits in base phase
  a_dot_in_base: assert property (@(posedge clk) disable iff (rst)
    last_was_dot |-> phase == PH_BASE)
    else $error("pending dot outside base phase");

endmodule
